/* rtl/olvr_pkg.sv */
`default_nettype none

package olvr_pkg;

  typedef enum logic [1:0] {
    ACT_APPEND   = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_POP_HEAD = 2'd2,
    ACT_POP_TAIL = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  localparam int unsigned ActionW = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned CountW  = 5;

endpackage

`default_nettype wire

/* rtl/olvr_if.sv */
`default_nettype none

interface olvr_in_if;
  logic                               valid;
  logic                               ready;
  logic [olvr_pkg::ActionW-1:0]       action;
  logic signed [olvr_pkg::ValueW-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink (input valid, input action, input value, output ready);
endinterface

interface olvr_out_if;
  logic                               valid;
  logic                               ready;
  logic [olvr_pkg::StatusW-1:0]       status;
  logic signed [olvr_pkg::ValueW-1:0] removed_value;
  logic [olvr_pkg::CountW-1:0]        entry_count;

  modport source (output valid, output status, output removed_value, output entry_count,
                  input ready);
  modport sink (input valid, input status, input removed_value, input entry_count,
                output ready);
endinterface

`default_nettype wire

/* rtl/ordered_list_with_value_removal_unit.sv */
`default_nettype none

// Channel  Dir  Beat fields                                 Handshake
// in_i     in   action[1:0], value[31:0]                    valid/ready
// out_o    out  status[1:0], removed_value[31:0],
//               entry_count[4:0]                            valid/ready
//
// One beat in flight at a time; in_i.ready is high only while the sequencer idles.
// Append, or any removal on an empty list, goes straight from accept to the result state.
// Pop tail reads the last slot only. Remove first match and pop head walk every entry
// of the one-read one-write slot memory, one slot per cycle (compare and shift).
// A result waits in the output register; a stalled out_o holds the sequencer in its
// final state. Reset clears the count and control; slot contents are not cleared.

module ordered_list_with_value_removal_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  olvr_in_if.sink     in_i,
  olvr_out_if.source  out_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned VW = olvr_pkg::ValueW;
  localparam int unsigned NW = olvr_pkg::CountW;

  olvr_pkg::state_e  state_q, state_d;
  olvr_pkg::action_e act_q, act_d;
  olvr_pkg::status_e res_status_q, res_status_d;

  logic [CW-1:0]        fill_q, fill_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic                 have_q, have_d;
  logic                 found_q, found_d;
  logic signed [VW-1:0] taken_q, taken_d;
  logic signed [VW-1:0] val_q, val_d;

  logic signed [VW-1:0] mem_q [CAPACITY];
  logic signed [VW-1:0] rd_data_q;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic signed [VW-1:0] wr_data;
  logic [CW-1:0]        wr_pos;
  logic                 hit;
  logic                 out_load;

  logic                 out_valid_q;
  olvr_pkg::status_e    out_status_q;
  logic signed [VW-1:0] out_value_q;
  logic [NW-1:0]        out_count_q;
  logic [CW+NW-1:0]     count_ext;

  assign in_i.ready          = (state_q == olvr_pkg::ST_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.removed_value = out_value_q;
  assign out_o.entry_count   = out_count_q;

  assign count_ext = {{NW{1'b0}}, fill_q};
  assign wr_pos    = idx_q - CW'(2);
  assign hit       = (act_q != olvr_pkg::ACT_REMOVE) || (rd_data_q == val_q);

  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    res_status_d = res_status_q;
    fill_d       = fill_q;
    idx_d        = idx_q;
    have_d       = have_q;
    found_d      = found_q;
    taken_d      = taken_q;
    val_d        = val_q;
    rd_en        = 1'b0;
    rd_addr      = idx_q[AW-1:0];
    wr_en        = 1'b0;
    wr_addr      = wr_pos[AW-1:0];
    wr_data      = rd_data_q;
    out_load     = 1'b0;

    case (state_q)
      olvr_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          act_d   = olvr_pkg::action_e'(in_i.action);
          val_d   = in_i.value;
          taken_d = '0;
          found_d = 1'b0;
          have_d  = 1'b0;
          if (olvr_pkg::action_e'(in_i.action) == olvr_pkg::ACT_APPEND) begin
            if (fill_q == CW'(CAPACITY)) begin
              res_status_d = olvr_pkg::STAT_FULL;
            end else begin
              wr_en        = 1'b1;
              wr_addr      = fill_q[AW-1:0];
              wr_data      = in_i.value;
              fill_d       = fill_q + CW'(1);
              res_status_d = olvr_pkg::STAT_DONE;
            end
            state_d = olvr_pkg::ST_DONE;
          end else if (fill_q == '0) begin
            res_status_d = olvr_pkg::STAT_EMPTY;
            state_d      = olvr_pkg::ST_DONE;
          end else begin
            if (olvr_pkg::action_e'(in_i.action) == olvr_pkg::ACT_POP_TAIL) begin
              idx_d = fill_q - CW'(1);
            end else begin
              idx_d = '0;
            end
            state_d = olvr_pkg::ST_SCAN;
          end
        end
      end
      olvr_pkg::ST_SCAN: begin
        rd_en  = (idx_q < fill_q);
        have_d = rd_en;
        if (rd_en) begin
          idx_d = idx_q + CW'(1);
        end
        if (have_q) begin
          if (!found_q && hit) begin
            found_d = 1'b1;
            taken_d = rd_data_q;
          end
          if (found_q) begin
            wr_en = 1'b1;
          end
          if (idx_q == fill_q) begin
            state_d = olvr_pkg::ST_DONE;
            if (found_q || hit) begin
              fill_d       = fill_q - CW'(1);
              res_status_d = olvr_pkg::STAT_DONE;
            end else begin
              res_status_d = olvr_pkg::STAT_NOT_FOUND;
            end
          end
        end
      end
      olvr_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = olvr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = olvr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= olvr_pkg::ST_IDLE;
      fill_q      <= '0;
      idx_q       <= '0;
      have_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      have_q  <= have_d;
      found_q <= found_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    val_q        <= val_d;
    taken_q      <= taken_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_value_q  <= taken_q;
      out_count_q  <= count_ext[NW-1:0];
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == olvr_pkg::ST_SCAN) |-> (fill_q != '0) && (idx_q <= fill_q))
    else $error("scan on empty list or index past count");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("new beat taken while previous one is in work");

  a_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == olvr_pkg::ST_SCAN && wr_en) |-> found_q && (act_q != olvr_pkg::ACT_POP_TAIL))
    else $error("slot shift without a removed entry");
`endif

endmodule

`default_nettype wire

/* tb/ordered_list_with_value_removal_unit_tb.sv */
`timescale 1ns / 100ps

typedef struct packed {
  olvr_pkg::status_e status;
  logic [31:0]       removed;
  logic [4:0]        count;
} list_result_t;

class list_scoreboard #(int Capacity = 16);
  logic [31:0]  slots [Capacity];
  int           fill;
  list_result_t pending [$];
  int           errors;
  int           beats;
  int           peak_fill;
  int           status_hits [4];

  function new();
    fill      = 0;
    errors    = 0;
    beats     = 0;
    peak_fill = 0;
    foreach (status_hits[i]) status_hits[i] = 0;
  endfunction

  function void note_beat(olvr_pkg::action_e act, logic [31:0] val);
    list_result_t exp;
    int           pos;
    exp.status  = olvr_pkg::STAT_DONE;
    exp.removed = '0;
    if (act == olvr_pkg::ACT_APPEND) begin
      if (fill >= Capacity) begin
        exp.status = olvr_pkg::STAT_FULL;
      end else begin
        slots[fill] = val;
        fill++;
      end
    end else if (fill == 0) begin
      exp.status = olvr_pkg::STAT_EMPTY;
    end else if (act == olvr_pkg::ACT_POP_TAIL) begin
      exp.removed = slots[fill - 1];
      fill--;
    end else begin
      pos = 0;
      if (act == olvr_pkg::ACT_REMOVE) begin
        pos = fill;
        for (int i = 0; i < fill && pos == fill; i++) begin
          if (slots[i] == val) pos = i;
        end
      end
      if (pos == fill) begin
        exp.status = olvr_pkg::STAT_NOT_FOUND;
      end else begin
        exp.removed = slots[pos];
        for (int i = pos; i + 1 < fill; i++) slots[i] = slots[i + 1];
        fill--;
      end
    end
    exp.count = 5'(fill);
    if (fill > peak_fill) peak_fill = fill;
    status_hits[int'(exp.status)]++;
    beats++;
    pending.push_back(exp);
  endfunction

  function void check_result(logic [1:0] st, logic [31:0] rv, logic [4:0] cnt);
    list_result_t exp;
    if (pending.size() == 0) begin
      $error("result beat with nothing pending: status %0d removed_value %0d entry_count %0d",
             st, $signed(rv), cnt);
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (st !== exp.status) begin
      $error("status: expected %0d, actual %0d", exp.status, st);
      errors++;
    end
    if (rv !== exp.removed) begin
      $error("removed_value: expected %0d, actual %0d", $signed(exp.removed), $signed(rv));
      errors++;
    end
    if (cnt !== exp.count) begin
      $error("entry_count: expected %0d, actual %0d", exp.count, cnt);
      errors++;
    end
  endfunction

  function int outstanding();
    return pending.size();
  endfunction
endclass

module ordered_list_with_value_removal_unit_tb;
  localparam int Capacity   = 16;
  localparam int WatchLimit = 2000;
  localparam int LongHold   = 300;
  localparam int RandEpochs = 20;
  localparam int EpochItems = 100;

  logic clk_i;
  logic rst_ni;

  olvr_in_if  in_bus ();
  olvr_out_if out_bus ();

  ordered_list_with_value_removal_unit #(
    .CAPACITY(Capacity)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  list_scoreboard #(Capacity) sb;

  int          send_idle_max = 6;
  int          recv_idle_max = 6;
  bit          hold_off_req  = 1'b0;
  int          idle_cycles   = 0;
  logic [31:0] value_pool [$];

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (in_bus.valid && in_bus.ready) begin
        sb.note_beat(olvr_pkg::action_e'(in_bus.action), in_bus.value);
      end
      if (out_bus.valid && out_bus.ready) begin
        sb.check_result(out_bus.status, out_bus.removed_value, out_bus.entry_count);
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= WatchLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin : receiver
    int hold;
    out_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = $urandom_range(0, recv_idle_max);
      if (hold_off_req) begin
        hold         = LongHold;
        hold_off_req = 1'b0;
      end
      if (hold > 0) begin
        out_bus.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
    end
  end

  // hold valid through a gap of 0 so back-to-back beats never lower it
  task automatic send_beat(olvr_pkg::action_e act, logic [31:0] val);
    int gap;
    gap = $urandom_range(0, send_idle_max);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid  <= 1'b1;
    in_bus.action <= act;
    in_bus.value  <= val;
    do @(posedge clk_i); while (!in_bus.ready);
    if (act == olvr_pkg::ACT_APPEND) begin
      value_pool.push_back(val);
      if (value_pool.size() > 64) void'(value_pool.pop_front());
    end
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() > 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value(bit for_removal);
    int          r;
    logic [31:0] tiny;
    r    = $urandom_range(0, 9);
    tiny = 32'($urandom_range(0, 8)) - 32'd4;
    if (for_removal) begin
      if (r < 6 && value_pool.size() > 0) begin
        return value_pool[$urandom_range(0, value_pool.size() - 1)];
      end
      if (r < 8) return tiny;
      return $urandom;
    end
    if (r < 3) return tiny;
    if (r == 3) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  task automatic run_directed();
    send_beat(olvr_pkg::ACT_POP_HEAD, 32'h0000_0000);
    send_beat(olvr_pkg::ACT_POP_TAIL, 32'hFFFF_FFFF);
    send_beat(olvr_pkg::ACT_REMOVE, 32'h8000_0000);
    send_beat(olvr_pkg::ACT_APPEND, 32'h8000_0000);
    send_beat(olvr_pkg::ACT_APPEND, 32'd7);
    send_beat(olvr_pkg::ACT_APPEND, 32'h7FFF_FFFF);
    send_beat(olvr_pkg::ACT_APPEND, 32'd7);
    send_beat(olvr_pkg::ACT_APPEND, 32'h0000_0000);
    send_beat(olvr_pkg::ACT_APPEND, 32'hFFFF_FFFF);
    for (int i = 6; i < Capacity; i++) begin
      send_beat(olvr_pkg::ACT_APPEND, 32'(i) * 32'h1111_1111);
    end
    send_beat(olvr_pkg::ACT_APPEND, 32'h5555_AAAA);
    send_beat(olvr_pkg::ACT_REMOVE, 32'd7);
    send_beat(olvr_pkg::ACT_REMOVE, 32'h1234_5678);
    send_beat(olvr_pkg::ACT_POP_TAIL, 32'h0000_0000);
    send_beat(olvr_pkg::ACT_POP_HEAD, 32'h0000_0000);
    send_beat(olvr_pkg::ACT_REMOVE, 32'd7);
    wait_drained();
  endtask

  task automatic run_epoch(int epoch);
    int                w_app;
    int                w_rem;
    int                w_head;
    int                pick;
    olvr_pkg::action_e act;
    logic [31:0]       val;
    case (epoch % 4)
      0: begin
        w_app = 70; w_rem = 15; w_head = 8;
      end
      1: begin
        w_app = 25; w_rem = 35; w_head = 20;
      end
      2: begin
        w_app = 50; w_rem = 25; w_head = 12;
      end
      default: begin
        w_app = 45; w_rem = 45; w_head = 5;
      end
    endcase
    send_idle_max = (epoch % 5 == 2) ? 0 : 6;
    recv_idle_max = (epoch % 5 == 2) ? 0 : 6;
    if (epoch == 3 || epoch == 12) hold_off_req = 1'b1;
    for (int n = 0; n < EpochItems; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < w_app) act = olvr_pkg::ACT_APPEND;
      else if (pick < w_app + w_rem) act = olvr_pkg::ACT_REMOVE;
      else if (pick < w_app + w_rem + w_head) act = olvr_pkg::ACT_POP_HEAD;
      else act = olvr_pkg::ACT_POP_TAIL;
      val = pick_value(act == olvr_pkg::ACT_REMOVE);
      send_beat(act, val);
    end
    if (epoch % 3 == 1) wait_drained();
  endtask

  initial begin : stimulus
    sb = new();
    rst_ni        <= 1'b0;
    in_bus.valid  <= 1'b0;
    in_bus.action <= olvr_pkg::ACT_APPEND;
    in_bus.value  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int e = 0; e < RandEpochs; e++) run_epoch(e);
    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("covered %0d list operations, fill reached %0d of %0d entries",
             sb.beats, sb.peak_fill, Capacity);
    $display("outcomes: %0d done, %0d on empty, %0d not found, %0d dropped on full",
             sb.status_hits[0], sb.status_hits[1], sb.status_hits[2], sb.status_hits[3]);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
